>>> hdl/csc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg
// Types, constants and helpers shared by the circle/segment contact block.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Shared div/sqrt unit widths
  localparam int REM_W = 68;
  localparam int DVD_W = 48;
  localparam int DSR_W = 66;
  localparam int QUO_W = 38;
  localparam int STEP_W = 6;

  // Step counts of the shared unit
  localparam logic [STEP_W-1:0] DIV_T_STEPS = 6'd31;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd24;
  localparam logic [STEP_W-1:0] NORM_STEPS = 6'd38;

  // Unit length of the normal, Q2.14
  localparam logic [14:0] NORM_ONE = 15'd16384;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_END_X   = 3'd2,
    CFG_END_Y   = 3'd3,
    CFG_LIMIT   = 3'd4
  } csc_cfg_idx_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_SEL, S_DIV,
    S_O0, S_O1, S_O2, S_DD, S_Q0, S_Q1, S_Q2, S_Q3,
    S_SQ, S_NX, S_NY, S_OUT
  } csc_state_t;

  // Control of the shared div/sqrt unit
  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [STEP_W-1:0] steps;
  } csc_ds_ctrl_t;

  // Magnitude of a 33-bit difference of two 32-bit values
  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic [32:0] u;
    u = v[32] ? 33'(-v) : 33'(v);
    return u[31:0];
  endfunction

  // Clamp a normal quotient and apply the sign
  function automatic logic [15:0] norm_comp(input logic [QUO_W-1:0] q, input logic neg);
    logic [15:0] m;
    m = (q > QUO_W'(NORM_ONE)) ? {1'b0, NORM_ONE} : {1'b0, q[14:0]};
    return neg ? 16'(-m) : m;
  endfunction

endpackage
`default_nettype wire

>>> hdl/csc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_if
// Valid/ready channels for circle items and contact results.
// ----------------------------------------------------------------------------
interface csc_in_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic [15:0]        body_index;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;
  logic [23:0]        radius;

  modport source(output valid, frame_start, body_index, centre_x, centre_y, radius,
                 input ready);
  modport sink(input valid, frame_start, body_index, centre_x, centre_y, radius,
               output ready);
endinterface

interface csc_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               limit_reached;
  logic [15:0]        body_tag;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic [23:0]        penetration;
  logic [15:0]        contact_total;

  modport source(output valid, hit, limit_reached, body_tag, normal_x, normal_y,
                 penetration, contact_total, input ready);
  modport sink(input valid, hit, limit_reached, body_tag, normal_x, normal_y,
               penetration, contact_total, output ready);
endinterface
`default_nettype wire

>>> hdl/csc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module csc_mul
  import csc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod_r
);

  // One product per cycle, available the cycle after issue
  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end

endmodule
`default_nettype wire

>>> hdl/csc_divsqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_divsqrt
// Shared restoring divider / square root, one quotient or root bit a cycle.
// ----------------------------------------------------------------------------
module csc_divsqrt
  import csc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire csc_ds_ctrl_t     ctrl,
  input  wire logic [REM_W-1:0] rem_init,
  input  wire logic [DVD_W-1:0] dvd_init,
  input  wire logic [DSR_W-1:0] divisor,
  output logic                  done_r,
  output logic      [QUO_W-1:0] quo_r
);

  logic              busy_r;
  logic              sqrt_r;
  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DSR_W-1:0]  dsr_r;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // One step: bring in the next dividend bit(s), trial-subtract
  always_comb begin
    if (sqrt_r) begin
      shifted = {rem_r[REM_W-3:0], dvd_r[DVD_W-1 -: 2]};
      trial   = REM_W'({quo_r, 2'b01});
    end else begin
      shifted = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
      trial   = REM_W'(dsr_r);
    end
    ge = (shifted >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctrl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sqrt_r <= ctrl.sqrt_mode;
      rem_r  <= rem_init;
      dvd_r  <= dvd_init;
      dsr_r  <= divisor;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? (shifted - trial) : shifted;
      quo_r <= {quo_r[QUO_W-2:0], ge};
      dvd_r <= sqrt_r ? {dvd_r[DVD_W-3:0], 2'b00} : {dvd_r[DVD_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

>>> hdl/circle_segment_contact_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_segment_contact_core
// Circle versus fixed line segment contact test with per-frame contact limit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one circle item (centre, radius, index, frame_start) per handshake.
//   out_ch : one result item per circle: hit, limit flag, normal, penetration,
//            running contact total of the frame.
//   cfg_*  : segment end points and contact limit, written while idle.
// Timing: one item at a time, in_ch.ready is high only when idle. Every item
//   goes through the projection, the offset to the nearest point and the box
//   test; an interior point adds the 31-bit division and the offsets, a circle
//   inside the box adds the distance test, and a reported contact adds the
//   24-bit square root and, when the distance is not zero, the two 38-step
//   normal divisions.
//   The shared bit-serial divide/root unit serves these steps.
// A finished result sits in the output register; the next item is accepted
//   while it waits, and only the following result stalls on out_ch.ready.
// Reset: contact counter 0, segment all zero, contact limit 65535, no result
//   pending.
// ----------------------------------------------------------------------------
module circle_segment_contact_core
  import csc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  csc_in_if.sink           in_ch,
  csc_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration
  logic signed [31:0] sx_r, sy_r, ex_r, ey_r;
  logic [15:0]        limit_r;

  // Item and working registers
  csc_state_t         state_r, state_nxt;
  logic [15:0]        tag_r;
  logic signed [31:0] cx_r, cy_r;
  logic [23:0]        rad_r;
  logic signed [32:0] dx_r, dy_r, lx_r, ly_r;
  logic signed [66:0] proj_r;
  logic [65:0]        len2_r;
  logic [30:0]        t_r;
  logic signed [33:0] px_r, py_r;
  logic [34:0]        mx_r, my_r;
  logic               dxneg_r, dyneg_r;
  logic [48:0]        d2_r;
  logic [23:0]        dist_r;
  logic [23:0]        pen_r;
  logic [15:0]        nx_r, ny_r;
  logic               hit_r, lim_r;
  logic [15:0]        count_r;

  // Result register
  logic               out_valid_r;
  logic               o_hit_r, o_lim_r;
  logic [15:0]        o_tag_r, o_nx_r, o_ny_r, o_total_r;
  logic [23:0]        o_pen_r;

  // Shared units
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod_r;
  csc_ds_ctrl_t       ds_ctrl;
  logic [REM_W-1:0]   ds_rem;
  logic [DVD_W-1:0]   ds_dvd;
  logic [DSR_W-1:0]   ds_dsr;
  logic               ds_done;
  logic [QUO_W-1:0]   ds_quo;

  logic               accept;
  logic               out_load;
  logic signed [66:0] prod_ext;
  logic               prod_neg;
  logic               in_box;
  logic               found;
  logic signed [33:0] off_ext;
  logic signed [34:0] ddx, ddy;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  csc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  csc_divsqrt u_ds (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ds_ctrl),
    .rem_init (ds_rem),
    .dvd_init (ds_dvd),
    .divisor  (ds_dsr),
    .done_r   (ds_done),
    .quo_r    (ds_quo)
  );

  // Shared helper terms
  always_comb begin
    prod_ext = $signed({3'b000, prod_r});
    prod_neg = (state_r == S_P1) ? (dx_r[32] ^ lx_r[32]) : (dy_r[32] ^ ly_r[32]);
    in_box   = (mx_r < 35'(rad_r)) && (my_r < 35'(rad_r));
    found    = (d2_r < {1'b0, prod_r[47:0]});
    off_ext  = $signed({1'b0, prod_r[63:31]});
    ddx      = 35'(cx_r) - 35'(px_r);
    ddy      = 35'(cy_r) - 35'(py_r);
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, multiplier operands and divide/root unit control
  always_comb begin
    state_nxt         = state_r;
    mul_a             = '0;
    mul_b             = '0;
    ds_ctrl.start     = 1'b0;
    ds_ctrl.sqrt_mode = 1'b0;
    ds_ctrl.steps     = DIV_T_STEPS;
    ds_rem            = '0;
    ds_dvd            = '0;
    ds_dsr            = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_P0;
      end
      S_P0: begin
        mul_a = mag33(dx_r); mul_b = mag33(lx_r); state_nxt = S_P1;
      end
      S_P1: begin
        mul_a = mag33(dy_r); mul_b = mag33(ly_r); state_nxt = S_P2;
      end
      S_P2: begin
        mul_a = mag33(lx_r); mul_b = mag33(lx_r); state_nxt = S_P3;
      end
      S_P3: begin
        mul_a = mag33(ly_r); mul_b = mag33(ly_r); state_nxt = S_P4;
      end
      S_P4: state_nxt = S_SEL;
      S_SEL: begin
        // Start cap, end cap or interior point
        if (proj_r <= 67'sd0 || proj_r >= $signed({1'b0, len2_r})) begin
          state_nxt = S_DD;
        end else begin
          ds_ctrl.start = 1'b1;
          ds_ctrl.steps = DIV_T_STEPS;
          ds_rem        = REM_W'(proj_r[65:0]);
          ds_dsr        = len2_r;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (ds_done) state_nxt = S_O0;
      end
      S_O0: begin
        mul_a = mag33(lx_r); mul_b = {1'b0, t_r}; state_nxt = S_O1;
      end
      S_O1: begin
        mul_a = mag33(ly_r); mul_b = {1'b0, t_r}; state_nxt = S_O2;
      end
      S_O2: state_nxt = S_DD;
      S_DD: state_nxt = S_Q0;
      S_Q0: begin
        mul_a = {8'd0, mx_r[23:0]}; mul_b = {8'd0, mx_r[23:0]};
        state_nxt = in_box ? S_Q1 : S_OUT;
      end
      S_Q1: begin
        mul_a = {8'd0, my_r[23:0]}; mul_b = {8'd0, my_r[23:0]}; state_nxt = S_Q2;
      end
      S_Q2: begin
        mul_a = {8'd0, rad_r}; mul_b = {8'd0, rad_r}; state_nxt = S_Q3;
      end
      S_Q3: begin
        if (found && (count_r < limit_r)) begin
          ds_ctrl.start     = 1'b1;
          ds_ctrl.sqrt_mode = 1'b1;
          ds_ctrl.steps     = SQRT_STEPS;
          ds_dvd            = d2_r[47:0];
          state_nxt         = S_SQ;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SQ: begin
        if (ds_done) begin
          if (ds_quo[23:0] != 24'd0) begin
            ds_ctrl.start = 1'b1;
            ds_ctrl.steps = NORM_STEPS;
            ds_dvd        = {mx_r[23:0], 24'd0};
            ds_dsr        = DSR_W'(ds_quo[23:0]);
            state_nxt     = S_NX;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_NX: begin
        if (ds_done) begin
          ds_ctrl.start = 1'b1;
          ds_ctrl.steps = NORM_STEPS;
          ds_dvd        = {my_r[23:0], 24'd0};
          ds_dsr        = DSR_W'(dist_r);
          state_nxt     = S_NY;
        end
      end
      S_NY: begin
        if (ds_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r    <= '0;
      sy_r    <= '0;
      ex_r    <= '0;
      ey_r    <= '0;
      limit_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_X: sx_r    <= cfg_data;
        CFG_START_Y: sy_r    <= cfg_data;
        CFG_END_X:   ex_r    <= cfg_data;
        CFG_END_Y:   ey_r    <= cfg_data;
        CFG_LIMIT:   limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Contact counter and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      hit_r   <= 1'b0;
      lim_r   <= 1'b0;
    end else begin
      if (accept) begin
        hit_r <= 1'b0;
        lim_r <= 1'b0;
        if (in_ch.frame_start) count_r <= '0;
      end else if (state_r == S_Q3 && found) begin
        if (count_r < limit_r) begin
          hit_r   <= 1'b1;
          count_r <= count_r + 1'b1;
        end else begin
          lim_r <= 1'b1;
        end
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        tag_r <= in_ch.body_index;
        cx_r  <= in_ch.centre_x;
        cy_r  <= in_ch.centre_y;
        rad_r <= in_ch.radius;
        dx_r  <= 33'(in_ch.centre_x) - 33'(sx_r);
        dy_r  <= 33'(in_ch.centre_y) - 33'(sy_r);
        lx_r  <= 33'(ex_r) - 33'(sx_r);
        ly_r  <= 33'(ey_r) - 33'(sy_r);
        pen_r <= '0;
        nx_r  <= '0;
        ny_r  <= '0;
      end
      S_P1: proj_r <= prod_neg ? -prod_ext : prod_ext;
      S_P2: proj_r <= prod_neg ? (proj_r - prod_ext) : (proj_r + prod_ext);
      S_P3: len2_r <= {2'b00, prod_r};
      S_P4: len2_r <= len2_r + {2'b00, prod_r};
      S_SEL: begin
        if (proj_r <= 67'sd0) begin
          px_r <= 34'(sx_r);
          py_r <= 34'(sy_r);
        end else begin
          px_r <= 34'(ex_r);
          py_r <= 34'(ey_r);
        end
      end
      S_DIV: t_r <= ds_quo[30:0];
      S_O1: px_r <= 34'(sx_r) + (lx_r[32] ? -off_ext : off_ext);
      S_O2: py_r <= 34'(sy_r) + (ly_r[32] ? -off_ext : off_ext);
      S_DD: begin
        mx_r    <= ddx[34] ? 35'(-ddx) : 35'(ddx);
        my_r    <= ddy[34] ? 35'(-ddy) : 35'(ddy);
        dxneg_r <= ddx[34];
        dyneg_r <= ddy[34];
      end
      S_Q1: d2_r <= prod_r[48:0];
      S_Q2: d2_r <= d2_r + prod_r[48:0];
      S_SQ: begin
        dist_r <= ds_quo[23:0];
        pen_r  <= rad_r - ds_quo[23:0];
      end
      S_NX: if (ds_done) nx_r <= norm_comp(ds_quo, dxneg_r);
      S_NY: if (ds_done) ny_r <= norm_comp(ds_quo, dyneg_r);
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_hit_r   <= hit_r;
      o_lim_r   <= lim_r;
      o_tag_r   <= tag_r;
      o_nx_r    <= nx_r;
      o_ny_r    <= ny_r;
      o_pen_r   <= pen_r;
      o_total_r <= count_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = o_hit_r;
  assign out_ch.limit_reached = o_lim_r;
  assign out_ch.body_tag      = o_tag_r;
  assign out_ch.normal_x      = o_nx_r;
  assign out_ch.normal_y      = o_ny_r;
  assign out_ch.penetration   = o_pen_r;
  assign out_ch.contact_total = o_total_r;

`ifndef SYNTHESIS
  // Divide/root completion only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ds_done |-> (state_r == S_DIV || state_r == S_SQ || state_r == S_NX ||
                 state_r == S_NY))
    else $error("div/sqrt done outside a wait state");

  // A reported contact is never also flagged as suppressed
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> !out_ch.limit_reached)
    else $error("hit and limit_reached both set");

  // A reported contact has been counted
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hit |-> out_ch.contact_total != 16'd0)
    else $error("hit with zero contact total");

  // One item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("ready right after accept");
`endif

endmodule
`default_nettype wire
